// ===== hdl/frs_pkg.sv =====
// ----------------------------------------------------------------------------
// frs_pkg - shared types and constants for the FASTA record splitter
// Character codes, parse modes, result kinds and the result bundle that the
// parser hands to the output buffer.
// ----------------------------------------------------------------------------
package frs_pkg;

  localparam int MAX_RESULTS = 3;
  localparam int CNT_W       = 2;

  localparam logic [7:0] CHAR_NL  = 8'h0A;
  localparam logic [7:0] CHAR_CR  = 8'h0D;
  localparam logic [7:0] CHAR_GT  = 8'h3E;
  localparam logic [7:0] CHAR_SP  = 8'h20;
  localparam logic [7:0] CHAR_TAB = 8'h09;
  localparam logic [7:0] CHAR_FF  = 8'h0C;

  typedef enum logic [2:0] {
    M_PRE      = 3'd0,
    M_HDR_ID   = 3'd1,
    M_HDR_SKIP = 3'd2,
    M_LSTART   = 3'd3,
    M_SEQ      = 3'd4,
    M_ERR      = 3'd5
  } mode_t;

  typedef enum logic [2:0] {
    K_ID    = 3'd0,
    K_SEQ   = 3'd1,
    K_END   = 3'd2,
    K_MAL   = 3'd3,
    K_NOREC = 3'd4
  } kind_t;

  typedef struct packed {
    logic [7:0] text_byte;
    logic       stream_end;
  } item_t;

  typedef struct packed {
    kind_t      kind;
    logic [7:0] data;
  } result_t;

  typedef struct packed {
    logic [CNT_W-1:0]             count;
    result_t [MAX_RESULTS-1:0]    slot;
  } bundle_t;

  // Append one result to a bundle; count never exceeds MAX_RESULTS here.
  function automatic bundle_t bundle_push(bundle_t b, kind_t k, logic [7:0] d);
    bundle_t r;
    r = b;
    case (b.count)
      2'd0: r.slot[0] = '{kind: k, data: d};
      2'd1: r.slot[1] = '{kind: k, data: d};
      2'd2: r.slot[2] = '{kind: k, data: d};
      default: ;
    endcase
    if (b.count != 2'd3) begin
      r.count = CNT_W'(b.count + 2'd1);
    end
    return r;
  endfunction

  function automatic logic is_sep(logic [7:0] b);
    return (b == CHAR_SP) || (b == CHAR_TAB) || (b == CHAR_FF);
  endfunction

endpackage

// ===== hdl/frs_ifs.sv =====
// ----------------------------------------------------------------------------
// frs_ifs - valid/ready channel interfaces of the FASTA record splitter
// Input channel carries raw text bytes, output channel carries results.
// ----------------------------------------------------------------------------
interface frs_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] text_byte;
  logic       stream_end;

  modport source (output valid, output text_byte, output stream_end, input ready);
  modport sink   (input valid, input text_byte, input stream_end, output ready);
endinterface

interface frs_out_if;
  logic       valid;
  logic       ready;
  logic [2:0] kind;
  logic [7:0] out_byte;
  logic       last_of_run;

  modport source (output valid, output kind, output out_byte, output last_of_run,
                  input ready);
  modport sink   (input valid, input kind, input out_byte, input last_of_run,
                  output ready);
endinterface

// ===== hdl/frs_in_reg.sv =====
// ----------------------------------------------------------------------------
// frs_in_reg - input register of the FASTA record splitter
// Captures one byte transaction; refills in the same cycle the parser takes it.
// ----------------------------------------------------------------------------
module frs_in_reg
  import frs_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  frs_in_if.sink     in_if,
  output logic       item_vld,
  output item_t      item,
  input  logic       item_take
);

  logic  vld_r, vld_nxt;
  item_t item_r;
  logic  load;

  assign in_if.ready = !vld_r || item_take;
  assign load        = in_if.valid && in_if.ready;

  always_comb begin
    vld_nxt = vld_r;
    if (load) begin
      vld_nxt = 1'b1;
    end else if (item_take) begin
      vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      item_r <= '{text_byte: in_if.text_byte, stream_end: in_if.stream_end};
    end
  end

  assign item_vld = vld_r;
  assign item     = item_r;

endmodule

// ===== hdl/frs_parse.sv =====
// ----------------------------------------------------------------------------
// frs_parse - per-byte parse step of the FASTA record splitter
// Holds the line mode, the held carriage return and the open-record flag, and
// turns one byte into a bundle of up to three results.
// ----------------------------------------------------------------------------
module frs_parse
  import frs_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    item_vld,
  input  item_t   item,
  output logic    item_take,
  output logic    bundle_vld,
  output bundle_t bundle,
  input  logic    bundle_rdy
);

  mode_t   mode_r, mode_nxt;
  logic    held_r, held_nxt;
  logic    have_r, have_nxt;
  bundle_t res;
  kind_t   data_kind;
  logic [7:0] b;

  assign b         = item.text_byte;
  assign data_kind = (mode_r == M_HDR_ID) ? K_ID : K_SEQ;

  always_comb begin
    mode_nxt = mode_r;
    held_nxt = held_r;
    have_nxt = have_r;
    res      = '0;
    case (mode_r)
      M_HDR_ID, M_SEQ: begin
        if (held_r && (b != CHAR_NL)) begin
          res = bundle_push(res, data_kind, CHAR_CR);
        end
        held_nxt = 1'b0;
        if (b == CHAR_NL) begin
          mode_nxt = M_LSTART;
        end else if (b == CHAR_CR) begin
          held_nxt = 1'b1;
        end else if ((mode_r == M_HDR_ID) && is_sep(b)) begin
          mode_nxt = M_HDR_SKIP;
        end else begin
          res = bundle_push(res, data_kind, b);
        end
      end
      M_HDR_SKIP: begin
        if (b == CHAR_NL) begin
          mode_nxt = M_LSTART;
        end
      end
      M_LSTART: begin
        if (b == CHAR_NL) begin
          mode_nxt = M_LSTART;
        end else if (b == CHAR_GT) begin
          res      = bundle_push(res, K_END, 8'h00);
          mode_nxt = M_HDR_ID;
        end else if (b == CHAR_CR) begin
          held_nxt = 1'b1;
          mode_nxt = M_SEQ;
        end else begin
          res      = bundle_push(res, K_SEQ, b);
          mode_nxt = M_SEQ;
        end
      end
      M_ERR: begin
        res = bundle_push(res, K_MAL, 8'h00);
      end
      default: begin
        if (b == CHAR_NL) begin
          mode_nxt = M_PRE;
        end else if (b == CHAR_GT) begin
          mode_nxt = M_HDR_ID;
          have_nxt = 1'b1;
        end else begin
          mode_nxt = M_ERR;
          held_nxt = 1'b0;
          res      = bundle_push(res, K_MAL, 8'h00);
        end
      end
    endcase

    // close out the stream after the byte itself
    if (item.stream_end && (mode_nxt != M_ERR)) begin
      held_nxt = 1'b0;
      res      = bundle_push(res, have_nxt ? K_END : K_NOREC, 8'h00);
      mode_nxt = M_PRE;
      have_nxt = 1'b0;
    end
  end

  assign bundle     = res;
  assign bundle_vld = item_vld && (res.count != '0);
  assign item_take  = item_vld && ((res.count == '0) || bundle_rdy);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= M_PRE;
      held_r <= 1'b0;
      have_r <= 1'b0;
    end else if (item_take) begin
      mode_r <= mode_nxt;
      held_r <= held_nxt;
      have_r <= have_nxt;
    end
  end

`ifndef SYNTHESIS
  a_err_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    (mode_r == M_ERR) |=> (mode_r == M_ERR))
    else $error("error mode left without reset");

  a_held_only_in_line: assert property (@(posedge clk) disable iff (!rst_n)
    held_r |-> ((mode_r == M_HDR_ID) || (mode_r == M_SEQ)))
    else $error("carriage return held outside a data line");

  a_take_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (item_vld && (res.count == '0)) |-> item_take)
    else $error("byte without results not taken");
`endif

endmodule

// ===== hdl/frs_out_buf.sv =====
// ----------------------------------------------------------------------------
// frs_out_buf - result register of the FASTA record splitter
// Holds one bundle and presents its results one transaction at a time.
// ----------------------------------------------------------------------------
module frs_out_buf
  import frs_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       bundle_vld,
  input  bundle_t    bundle,
  output logic       bundle_rdy,
  frs_out_if.source  out_if
);

  logic             vld_r;
  logic [CNT_W-1:0] idx_r;
  bundle_t          bun_r;
  result_t          cur;
  logic             is_last, pop, last_pop, load;

  always_comb begin
    case (idx_r)
      2'd0:    cur = bun_r.slot[0];
      2'd1:    cur = bun_r.slot[1];
      2'd2:    cur = bun_r.slot[2];
      default: cur = bun_r.slot[0];
    endcase
  end

  assign is_last    = (idx_r == CNT_W'(bun_r.count - 2'd1));
  assign pop        = vld_r && out_if.ready;
  assign last_pop   = pop && is_last;
  assign bundle_rdy = !vld_r || last_pop;
  assign load       = bundle_vld && bundle_rdy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
      idx_r <= '0;
    end else if (load) begin
      vld_r <= 1'b1;
      idx_r <= '0;
    end else if (last_pop) begin
      vld_r <= 1'b0;
    end else if (pop) begin
      idx_r <= CNT_W'(idx_r + 2'd1);
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      bun_r <= bundle;
    end
  end

  assign out_if.valid       = vld_r;
  assign out_if.kind        = cur.kind;
  assign out_if.out_byte    = cur.data;
  assign out_if.last_of_run = is_last;

`ifndef SYNTHESIS
  a_idx_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    vld_r |-> ((bun_r.count != '0) && (idx_r < bun_r.count)))
    else $error("result index outside bundle");

  a_drain_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (last_pop && !bundle_vld) |=> !vld_r)
    else $error("buffer still valid after last result");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (vld_r && !last_pop) |-> !load)
    else $error("bundle loaded over pending results");
`endif

endmodule

// ===== hdl/fasta_record_splitter.sv =====
// ----------------------------------------------------------------------------
// fasta_record_splitter - splits a FASTA byte stream into ids and sequences
// Top level: input register, parse step and result buffer.
// ----------------------------------------------------------------------------
// Each input transaction is one text byte with a flag on the final byte of the
// stream. A byte yields zero to three result transactions (id byte, sequence
// byte, record end, malformed error, no record), and last_of_run marks the
// final result of each byte. Timing: a byte is captured by the input register
// at its input transaction, the parse step works on it in the next cycle, and
// its results are registered in the result buffer once that buffer takes the
// bundle, and they leave from there. The input takes one byte per cycle as long
// as each byte yields at most one result and the output is ready; a byte with
// several results holds the single result buffer until its last result has
// left. Bytes that yield nothing never wait on the output.
// Empty lines and carriage returns ahead of a newline vanish; after a bad
// first line every byte gives one malformed error until reset.
module fasta_record_splitter
  import frs_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  frs_in_if.sink     in_if,
  frs_out_if.source  out_if
);

  logic    item_vld;
  item_t   item;
  logic    item_take;
  logic    bundle_vld;
  bundle_t bundle;
  logic    bundle_rdy;

  // Hold the incoming byte transaction.
  frs_in_reg u_in_reg (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_if     (in_if),
    .item_vld  (item_vld),
    .item      (item),
    .item_take (item_take)
  );

  // Advance the parse state and build the results of one byte.
  frs_parse u_parse (
    .clk        (clk),
    .rst_n      (rst_n),
    .item_vld   (item_vld),
    .item       (item),
    .item_take  (item_take),
    .bundle_vld (bundle_vld),
    .bundle     (bundle),
    .bundle_rdy (bundle_rdy)
  );

  // Drain the results one transaction per cycle while the output is ready.
  frs_out_buf u_out_buf (
    .clk        (clk),
    .rst_n      (rst_n),
    .bundle_vld (bundle_vld),
    .bundle     (bundle),
    .bundle_rdy (bundle_rdy),
    .out_if     (out_if)
  );

endmodule
